// ===== rtl/core/shbr_pkg.sv =====
// Shared types and constants for the stuffed header bit reader.
// No dependencies; every other file of the block imports this package.
package shbr_pkg;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 6;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;
	localparam int DROP_W   = 6;

	// Depth of the queue between the front and back parts; a power of two.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] BYTE_FF = 8'hFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_READ = 2'd1,
		CMD_SYNC = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One classified command word as it travels through the queue.
	typedef struct packed {
		cmd_t              op;
		logic [BYTE_W-1:0] byte_val;
		logic [CNT_W-1:0]  bit_cnt;
		logic              cnt_zero;
		logic              cnt_over;
		logic              byte_ff;
	} entry_t;

endpackage

// ===== rtl/core/shbr_if.sv =====
// Valid/ready channel interfaces for the command and result words.
// Depends on shbr_pkg for field widths.
interface shbr_in_if import shbr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] byte_in;
	logic [CNT_W-1:0]  bit_count;

	modport source (output valid, command, byte_in, bit_count, input ready);
	modport sink (input valid, command, byte_in, bit_count, output ready);
endinterface

interface shbr_out_if import shbr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   bits_out;
	logic [DROP_W-1:0]   dropped_bits;
	logic                stuff_owed;

	modport source (output valid, status, bits_out, dropped_bits, stuff_owed, input ready);
	modport sink (input valid, status, bits_out, dropped_bits, stuff_owed, output ready);
endinterface

// ===== rtl/core/stuffed_header_bit_reader_unit.sv =====
// An accepted word is written into the queue; the back part then executes it and registers
// its result. Throughput: one word per cycle while rsp.ready holds; each word takes one
// pass of the execute step on the bit store, and a two-entry queue decouples both sides.
// Reset (arst_n low, asynchronous) empties the queue, clears the bit store, the fill
// count and the 0xFF flag, and drops any result word that was waiting.
module stuffed_header_bit_reader_unit import shbr_pkg::*; #(
	parameter int STORE_BITS = 48,
	parameter int MAX_READ   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	shbr_in_if.sink    req,
	shbr_out_if.source rsp
);

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t q_in;
	entry_t q_head;

	shbr_front #(
		.MAX_READ (MAX_READ)
	) u_front (
		.req     (req),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_in)
	);

	shbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	shbr_back #(
		.STORE_BITS (STORE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.rsp        (rsp)
	);

endmodule

// ===== rtl/core/shbr_front.sv =====
// Front part: accepts command words and classifies them for the back part.
// Depends on shbr_pkg and shbr_in_if.
module shbr_front import shbr_pkg::*; #(
	parameter int MAX_READ = 32
) (
	shbr_in_if.sink  req,
	input  logic     q_full,
	output logic     q_push,
	output entry_t   q_entry
);

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		q_entry.op       = cmd_t'(req.command);
		q_entry.byte_val = req.byte_in;
		q_entry.bit_cnt  = req.bit_count;
		q_entry.cnt_zero = (req.bit_count == '0);
		q_entry.cnt_over = (req.bit_count > CNT_W'(MAX_READ));
		q_entry.byte_ff  = (req.byte_in == BYTE_FF);
	end

endmodule

// ===== rtl/core/shbr_queue.sv =====
// Short queue of classified command words between the front and back parts.
// Depends on shbr_pkg.
module shbr_queue import shbr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// ===== rtl/core/shbr_back.sv =====
// Back part: owns the bit store, executes push, read and synchronize words,
// and holds the result word in an output register. Depends on shbr_pkg, shbr_out_if.
module shbr_back import shbr_pkg::*; #(
	parameter int STORE_BITS = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  logic      head_valid,
	output logic      pop,
	shbr_out_if.source rsp
);

	localparam int FW = $clog2(STORE_BITS + 1);

	logic [STORE_BITS-1:0] store_q;
	logic [FW-1:0]         fill_q;
	logic                  ff_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [DATA_W-1:0]     bits_q;
	logic [DROP_W-1:0]     dropped_q;
	logic                  owed_q;

	logic [STORE_BITS-1:0] store_d;
	logic [FW-1:0]         fill_d;
	logic                  ff_d;
	status_t               status_d;
	logic [DATA_W-1:0]     bits_d;
	logic [DROP_W-1:0]     dropped_d;
	logic                  owed_d;

	logic [3:0]            add;
	logic [FW:0]           fill_sum;
	logic [STORE_BITS-1:0] push_store;
	logic                  read_short;
	logic [FW-1:0]         sh;
	logic [STORE_BITS-1:0] shifted;
	logic [DATA_W-1:0]     lsb_mask;
	logic [STORE_BITS-1:0] keep_mask;

	assign pop = head_valid && (!out_valid_q || rsp.ready);

	always_comb begin
		// After a 0xFF byte, the top bit of the next byte is a stuffed zero.
		add        = ff_q ? 4'd7 : 4'd8;
		fill_sum   = {1'b0, fill_q} + (FW+1)'(add);
		push_store = ff_q ? {store_q[STORE_BITS-8:0], head.byte_val[6:0]}
		                  : {store_q[STORE_BITS-9:0], head.byte_val};
		read_short = head.cnt_over || ((FW+1)'(head.bit_cnt) > {1'b0, fill_q});
		sh         = fill_q - FW'(head.bit_cnt);
		shifted    = store_q >> sh;
		lsb_mask   = {DATA_W{1'b1}} >> (CNT_W'(DATA_W) - head.bit_cnt);
		keep_mask  = ~({STORE_BITS{1'b1}} << sh);

		store_d   = store_q;
		fill_d    = fill_q;
		ff_d      = ff_q;
		status_d  = ST_OK;
		bits_d    = '0;
		dropped_d = '0;
		owed_d    = 1'b0;

		case (head.op)
			CMD_PUSH: begin
				if (fill_sum > (FW+1)'(STORE_BITS)) begin
					status_d = ST_FULL;
				end else begin
					store_d = push_store;
					fill_d  = fill_sum[FW-1:0];
					ff_d    = head.byte_ff;
				end
			end
			CMD_READ: begin
				if (head.cnt_zero) begin
					status_d = ST_OK;
				end else if (read_short) begin
					status_d = ST_SHORT;
				end else begin
					bits_d  = shifted[DATA_W-1:0] & lsb_mask;
					fill_d  = sh;
					store_d = store_q & keep_mask;
				end
			end
			CMD_SYNC: begin
				dropped_d = DROP_W'(fill_q);
				owed_d    = ff_q;
				store_d   = '0;
				fill_d    = '0;
				ff_d      = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q     <= '0;
			fill_q      <= '0;
			ff_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				store_q     <= store_d;
				fill_q      <= fill_d;
				ff_q        <= ff_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= status_d;
			bits_q    <= bits_d;
			dropped_q <= dropped_d;
			owed_q    <= owed_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.bits_out     = bits_q;
	assign rsp.dropped_bits = dropped_q;
	assign rsp.stuff_owed   = owed_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_BITS))
		else $error("bit fill exceeds store size");

	a_store_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(store_q >> fill_q) == '0)
		else $error("stale bits above the fill level");

	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.op == CMD_SYNC) |=> (fill_q == '0 && !ff_q))
		else $error("synchronize left bits in the store");

endmodule
